@@ hw/rtl/opp_pkg.sv @@
`default_nettype none

package opp_pkg;

	// parse position inside one request packet
	typedef enum logic [3:0] {
		PH_OPCODE,
		PH_LEN_HI,
		PH_LEN_LO,
		PH_VER,
		PH_FLAGS,
		PH_MAX_HI,
		PH_MAX_LO,
		PH_HDR_ID,
		PH_HLEN_HI,
		PH_HLEN_LO,
		PH_HDATA,
		PH_SKIP
	} phase_t;

	typedef enum logic [1:0] {
		SES_WAITING,
		SES_CONNECTED,
		SES_RECEIVING,
		SES_DISCONN
	} session_t;

	typedef enum logic [1:0] {
		CLS_CONNECT,
		CLS_PUT,
		CLS_DISC,
		CLS_OTHER
	} pkt_class_t;

	// response packet to send when a packet ends
	typedef enum logic [2:0] {
		RSP_NONE,
		RSP_CONNECT,
		RSP_PUT_CONT,
		RSP_PUT_OK,
		RSP_DISC
	} rsp_t;

	localparam logic [7:0]  OP_CONNECT   = 8'h80;
	localparam logic [7:0]  OP_DISC      = 8'h81;
	localparam logic [7:0]  OP_PUT       = 8'h82;
	localparam logic [7:0]  FINAL_MASK   = 8'h80;
	localparam logic [7:0]  HDR_BODY     = 8'h48;
	localparam logic [7:0]  HDR_EOB      = 8'h49;
	localparam logic [7:0]  CODE_SUCCESS = 8'hA0;
	localparam logic [7:0]  CODE_CONT    = 8'h90;
	localparam logic [7:0]  RSP_LEN_LONG = 8'h07;
	localparam logic [7:0]  RSP_LEN_SHORT = 8'h03;
	localparam logic [7:0]  BYTE_ZERO    = 8'h00;
	localparam logic [15:0] FIXED_LEN    = 16'd3;
	localparam logic [15:0] CONNECT_LEN  = 16'd7;
	localparam logic [15:0] HLEN_OVERHEAD = 16'd3;
	localparam logic [1:0]  FORM_ONE_BYTE = 2'b10;
	localparam logic [1:0]  FORM_SEQ_MAX = 2'b01;
	localparam logic [15:0] REM_ONE_BYTE = 16'd1;
	localparam logic [15:0] REM_FOUR_BYTE = 16'd4;
	localparam logic [2:0]  LAST_IDX_LONG = 3'd6;
	localparam logic [2:0]  LAST_IDX_SHORT = 3'd2;

	// one unit of work handed from the parser to the output side
	typedef struct packed {
		logic        has_body;
		logic [7:0]  body;
		rsp_t        rsp;
		logic        mal;
		session_t    session;
		logic [7:0]  version;
		logic [15:0] max_size;
	} job_t;

	function automatic pkt_class_t classify(input logic [7:0] op);
		logic [7:0] c;
		pkt_class_t r;
		c = op | FINAL_MASK;
		unique case (c)
			OP_CONNECT: r = CLS_CONNECT;
			OP_PUT:     r = CLS_PUT;
			OP_DISC:    r = CLS_DISC;
			default:    r = CLS_OTHER;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] rsp_last_idx(input rsp_t rsp);
		return (rsp == RSP_CONNECT) ? LAST_IDX_LONG : LAST_IDX_SHORT;
	endfunction

	// byte idx of the response packet
	function automatic logic [7:0] rsp_byte(input rsp_t rsp, input logic [2:0] idx,
			input logic [7:0] ver, input logic [15:0] max_size);
		logic [7:0] r;
		r = BYTE_ZERO;
		if (rsp == RSP_CONNECT) begin
			case (idx)
				3'd0:    r = CODE_SUCCESS;
				3'd1:    r = BYTE_ZERO;
				3'd2:    r = RSP_LEN_LONG;
				3'd3:    r = ver;
				3'd4:    r = BYTE_ZERO;
				3'd5:    r = max_size[15:8];
				default: r = max_size[7:0];
			endcase
		end else begin
			case (idx)
				3'd0:    r = (rsp == RSP_PUT_CONT) ? CODE_CONT : CODE_SUCCESS;
				3'd1:    r = BYTE_ZERO;
				default: r = RSP_LEN_SHORT;
			endcase
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/opp_rx_if.sv @@
`default_nettype none

interface opp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/opp_tx_if.sv @@
`default_nettype none

interface opp_tx_if;
	logic       valid;
	logic       ready;
	logic       out_kind;
	logic [7:0] out_byte;
	logic       run_last;
	logic [1:0] session;
	logic       malformed;

	modport source (output valid, output out_kind, output out_byte, output run_last,
		output session, output malformed, input ready);
	modport sink (input valid, input out_kind, input out_byte, input run_last,
		input session, input malformed, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/obex_server_packet_parser_unit.sv @@
`default_nettype none

// OBEX server request parser. The rx channel takes one client byte per cycle
// whenever the job queue between parser and output side has room; each byte
// can give zero to eight tx beats (a body payload byte, then a 3-byte or
// 7-byte response when a packet ends), sent at one beat per cycle while the
// tx port is ready. The tx port therefore sets the sustained rate whenever
// the bytes give more beats than the rx side delivers, with the QueueDepth-entry
// queue absorbing bursts. A byte's job is written into the queue when the
// byte is taken, then loaded into the job register, and its first beat then
// goes into the output register. Every beat of one byte carries the session state after
// that byte; after a disconnect all input is taken and dropped.
module obex_server_packet_parser_unit #(
	parameter int QueueDepth = 4
) (
	input  wire       clk,
	input  wire       arst_n,
	opp_rx_if.sink    rx,
	opp_tx_if.source  tx
);
	import opp_pkg::*;

	logic fj_valid;
	logic fj_ready;
	job_t fj_data;
	logic bj_valid;
	logic bj_ready;
	job_t bj_data;

	// parser
	opp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.job_valid (fj_valid),
		.job_ready (fj_ready),
		.job       (fj_data)
	);

	// job queue
	opp_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fj_valid),
		.push_ready (fj_ready),
		.push_data  (fj_data),
		.pop_valid  (bj_valid),
		.pop_ready  (bj_ready),
		.pop_data   (bj_data)
	);

	// beat generator
	opp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (bj_valid),
		.job_ready (bj_ready),
		.job       (bj_data),
		.tx        (tx)
	);

endmodule

`default_nettype wire

@@ hw/rtl/opp_front.sv @@
`default_nettype none

module opp_front (
	input  wire            clk,
	input  wire            arst_n,
	opp_rx_if.sink         rx,
	output logic           job_valid,
	input  wire            job_ready,
	output opp_pkg::job_t  job
);
	import opp_pkg::*;

	phase_t      phase_q, phase_n;
	session_t    session_q, session_n;
	logic [7:0]  opcode_q, opcode_n;
	logic [15:0] plen_q, plen_n;
	logic [15:0] bcnt_q, bcnt_n;
	logic [7:0]  hcode_q, hcode_n;
	logic [15:0] hrem_q, hrem_n;
	logic [7:0]  lhi_q, lhi_n;
	logic [7:0]  ver_q, ver_n;
	logic [15:0] max_q, max_n;

	logic        step;
	logic [7:0]  b;
	logic [15:0] bcnt_inc;
	logic [15:0] len_full;
	logic [15:0] rem_dec;
	pkt_class_t  cls;
	logic        emit_body;
	logic        fin;
	logic        mal;
	rsp_t        rsp;

	// bytes are taken whenever the queue has room; disconnected drops them
	assign rx.ready = job_ready;
	assign step     = rx.valid && job_ready && (session_q != SES_DISCONN);
	assign b        = rx.in_byte;
	assign bcnt_inc = bcnt_q + 16'd1;
	assign len_full = {lhi_q, b};
	assign cls      = classify(opcode_q);
	assign rem_dec  = (hrem_q != 16'd0) ? (hrem_q - 16'd1) : 16'd0;

	// packet parser next state
	always_comb begin
		phase_n   = phase_q;
		session_n = session_q;
		opcode_n  = opcode_q;
		plen_n    = plen_q;
		bcnt_n    = bcnt_q;
		hcode_n   = hcode_q;
		hrem_n    = hrem_q;
		lhi_n     = lhi_q;
		ver_n     = ver_q;
		max_n     = max_q;
		emit_body = 1'b0;
		fin       = 1'b0;
		mal       = 1'b0;
		rsp       = RSP_NONE;
		unique case (phase_q)
			PH_OPCODE: begin
				opcode_n = b;
				bcnt_n   = 16'd1;
				phase_n  = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				lhi_n   = b;
				bcnt_n  = 16'd2;
				phase_n = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				plen_n = len_full;
				bcnt_n = FIXED_LEN;
				if (cls == CLS_CONNECT) begin
					phase_n = PH_VER;
				end else if (cls == CLS_OTHER) begin
					phase_n = (FIXED_LEN >= len_full) ? PH_OPCODE : PH_SKIP;
				end else if (FIXED_LEN >= len_full) begin
					fin = 1'b1;
				end else begin
					phase_n = PH_HDR_ID;
				end
			end
			PH_VER: begin
				ver_n   = b;
				bcnt_n  = 16'd4;
				phase_n = PH_FLAGS;
			end
			PH_FLAGS: begin
				bcnt_n  = 16'd5;
				phase_n = PH_MAX_HI;
			end
			PH_MAX_HI: begin
				max_n   = {b, BYTE_ZERO};
				bcnt_n  = 16'd6;
				phase_n = PH_MAX_LO;
			end
			PH_MAX_LO: begin
				max_n  = {max_q[15:8], b};
				bcnt_n = CONNECT_LEN;
				if (CONNECT_LEN >= plen_q) begin
					fin = 1'b1;
				end else begin
					phase_n = PH_HDR_ID;
				end
			end
			PH_SKIP: begin
				bcnt_n = bcnt_inc;
				if (bcnt_inc >= plen_q) begin
					phase_n = PH_OPCODE;
				end
			end
			PH_HDR_ID, PH_HLEN_HI, PH_HLEN_LO, PH_HDATA: begin
				bcnt_n = bcnt_inc;
				if (phase_q == PH_HDR_ID) begin
					hcode_n = b;
					if (b == HDR_BODY || b == HDR_EOB || b[7:6] <= FORM_SEQ_MAX) begin
						phase_n = PH_HLEN_HI;
					end else begin
						hrem_n  = (b[7:6] == FORM_ONE_BYTE) ? REM_ONE_BYTE : REM_FOUR_BYTE;
						phase_n = PH_HDATA;
					end
				end else if (phase_q == PH_HLEN_HI) begin
					lhi_n   = b;
					phase_n = PH_HLEN_LO;
				end else if (phase_q == PH_HLEN_LO) begin
					hrem_n  = (len_full >= HLEN_OVERHEAD) ? (len_full - HLEN_OVERHEAD) : 16'd0;
					phase_n = (len_full > HLEN_OVERHEAD) ? PH_HDATA : PH_HDR_ID;
				end else begin
					emit_body = (hcode_q == HDR_BODY) || (hcode_q == HDR_EOB);
					hrem_n    = rem_dec;
					if (rem_dec == 16'd0) begin
						phase_n = PH_HDR_ID;
					end
				end
				// packet length reached: inside a header means overrun
				if (bcnt_inc >= plen_q) begin
					fin = 1'b1;
					mal = (phase_n != PH_HDR_ID);
				end
			end
			default: begin
				phase_n = PH_OPCODE;
			end
		endcase
		// end of packet: pick the response and move the session
		if (fin) begin
			phase_n = PH_OPCODE;
			case (cls)
				CLS_CONNECT: begin
					rsp       = RSP_CONNECT;
					session_n = SES_CONNECTED;
				end
				CLS_PUT: begin
					rsp       = opcode_q[7] ? RSP_PUT_OK : RSP_PUT_CONT;
					session_n = opcode_q[7] ? SES_CONNECTED : SES_RECEIVING;
				end
				CLS_DISC: begin
					rsp       = RSP_DISC;
					session_n = SES_DISCONN;
				end
				default: begin
					rsp = RSP_NONE;
				end
			endcase
		end
	end

	// job toward the output side
	assign job_valid    = step && (emit_body || (rsp != RSP_NONE));
	assign job.has_body = emit_body;
	assign job.body     = b;
	assign job.rsp      = rsp;
	assign job.mal      = mal;
	assign job.session  = session_n;
	assign job.version  = ver_n;
	assign job.max_size = max_n;

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_OPCODE;
			session_q <= SES_WAITING;
			opcode_q  <= '0;
			plen_q    <= '0;
			bcnt_q    <= '0;
			hcode_q   <= '0;
			hrem_q    <= '0;
			lhi_q     <= '0;
			ver_q     <= '0;
			max_q     <= '0;
		end else if (step) begin
			phase_q   <= phase_n;
			session_q <= session_n;
			opcode_q  <= opcode_n;
			plen_q    <= plen_n;
			bcnt_q    <= bcnt_n;
			hcode_q   <= hcode_n;
			hrem_q    <= hrem_n;
			lhi_q     <= lhi_n;
			ver_q     <= ver_n;
			max_q     <= max_n;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/opp_queue.sv @@
`default_nettype none

module opp_queue #(
	parameter int Depth = 4
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            push_valid,
	output logic           push_ready,
	input  opp_pkg::job_t  push_data,
	output logic           pop_valid,
	input  wire            pop_ready,
	output opp_pkg::job_t  pop_data
);
	import opp_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

	job_t            mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (count_q != FullCnt);
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/opp_back.sv @@
`default_nettype none

module opp_back (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            job_valid,
	output logic           job_ready,
	input  opp_pkg::job_t  job,
	opp_tx_if.source       tx
);
	import opp_pkg::*;

	job_t       job_q;
	logic       busy_q;
	logic       body_pend_q;
	logic [2:0] idx_q;

	logic       tx_valid_q;
	logic       kind_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic [1:0] session_q;
	logic       mal_q;

	logic       beat_kind;
	logic [7:0] beat_byte;
	logic       beat_last;
	logic       beat_mal;
	logic       job_done;
	logic       advance;

	// next beat of the current job: body byte first, then response bytes
	always_comb begin
		if (body_pend_q) begin
			beat_kind = 1'b0;
			beat_byte = job_q.body;
			beat_last = 1'b1;
			beat_mal  = 1'b0;
			job_done  = (job_q.rsp == RSP_NONE);
		end else begin
			beat_kind = 1'b1;
			beat_byte = rsp_byte(job_q.rsp, idx_q, job_q.version, job_q.max_size);
			beat_last = (idx_q == rsp_last_idx(job_q.rsp));
			beat_mal  = job_q.mal;
			job_done  = beat_last;
		end
	end

	assign advance   = busy_q && (!tx_valid_q || tx.ready);
	assign job_ready = !busy_q || (advance && job_done);

	// job register and beat sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			body_pend_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (advance) begin
				if (body_pend_q) begin
					body_pend_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 3'd1;
				end
				if (job_done) begin
					busy_q <= 1'b0;
				end
			end
			if (job_valid && job_ready) begin
				busy_q      <= 1'b1;
				body_pend_q <= job.has_body;
				idx_q       <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_valid && job_ready) begin
			job_q <= job;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_valid_q <= 1'b0;
		end else if (advance) begin
			tx_valid_q <= 1'b1;
		end else if (tx.ready) begin
			tx_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			kind_q    <= beat_kind;
			byte_q    <= beat_byte;
			last_q    <= beat_last;
			session_q <= job_q.session;
			mal_q     <= beat_mal;
		end
	end

	assign tx.valid     = tx_valid_q;
	assign tx.out_kind  = kind_q;
	assign tx.out_byte  = byte_q;
	assign tx.run_last  = last_q;
	assign tx.session   = session_q;
	assign tx.malformed = mal_q;

endmodule

`default_nettype wire

@@ tb/tb_obex_server_packet_parser_unit.sv @@
`timescale 1ns / 100ps

module tb_obex_server_packet_parser_unit;
	import opp_pkg::*;

	localparam int         QUIET_LIMIT = 4000;
	localparam int         HOLD_CYCLES = 400;
	localparam int         TAIL_CYCLES = 24;
	localparam int         PHASE_BYTES = 50;
	localparam logic       KIND_BODY = 1'b0;
	localparam logic       KIND_REPLY = 1'b1;
	localparam logic [1:0] FORM_TEXT = 2'b00;
	localparam logic [1:0] FORM_FOUR_BYTE = 2'b11;
	localparam logic [7:0] SKIPPED_OP = 8'h7F;
	localparam logic [7:0] FOUR_BYTE_ID = 8'hC3;

	typedef enum {REQ_CONNECT, REQ_PUT, REQ_SKIP, REQ_BYE} req_kind_t;
	typedef enum {SHAPE_WHOLE, SHAPE_SHORT, SHAPE_CUT} shape_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] data;
		logic       last;
		logic [1:0] ses;
		logic       mal;
	} tx_beat_t;

	// tracks the server parse state and the tx beats still owed
	class obex_reply_book;
		tx_beat_t    owed_beats[$];
		int          beats_checked;
		int          beat_errors;
		session_t    ses;
		phase_t      phase;
		logic [7:0]  op;
		logic [7:0]  hdr_id;
		logic [7:0]  len_hi;
		logic [7:0]  version;
		logic [15:0] pkt_len;
		logic [15:0] seen;
		logic [15:0] hdr_left;
		logic [15:0] max_size;

		function new();
			ses = SES_WAITING;
			phase = PH_OPCODE;
			op = '0;
			hdr_id = '0;
			len_hi = '0;
			version = '0;
			pkt_len = '0;
			seen = '0;
			hdr_left = '0;
			max_size = '0;
			beats_checked = 0;
			beat_errors = 0;
		endfunction

		function pkt_class_t op_class();
			case (op | FINAL_MASK)
				OP_CONNECT: return CLS_CONNECT;
				OP_PUT:     return CLS_PUT;
				OP_DISC:    return CLS_DISC;
				default:    return CLS_OTHER;
			endcase
		endfunction

		function void owe(logic kind, logic [7:0] data, logic last, logic mal);
			tx_beat_t t;
			t.kind = kind;
			t.data = data;
			t.last = last;
			t.ses = '0;
			t.mal = mal;
			owed_beats.push_back(t);
		endfunction

		// response for the packet that just ended
		function void close_packet(logic mal);
			case (op_class())
				CLS_CONNECT: begin
					owe(KIND_REPLY, CODE_SUCCESS, 1'b0, mal);
					owe(KIND_REPLY, BYTE_ZERO, 1'b0, mal);
					owe(KIND_REPLY, RSP_LEN_LONG, 1'b0, mal);
					owe(KIND_REPLY, version, 1'b0, mal);
					owe(KIND_REPLY, BYTE_ZERO, 1'b0, mal);
					owe(KIND_REPLY, max_size[15:8], 1'b0, mal);
					owe(KIND_REPLY, max_size[7:0], 1'b1, mal);
					ses = SES_CONNECTED;
				end
				CLS_PUT: begin
					if ((op & FINAL_MASK) != 0) begin
						owe(KIND_REPLY, CODE_SUCCESS, 1'b0, mal);
						ses = SES_CONNECTED;
					end else begin
						owe(KIND_REPLY, CODE_CONT, 1'b0, mal);
						ses = SES_RECEIVING;
					end
					owe(KIND_REPLY, BYTE_ZERO, 1'b0, mal);
					owe(KIND_REPLY, RSP_LEN_SHORT, 1'b1, mal);
				end
				CLS_DISC: begin
					owe(KIND_REPLY, CODE_SUCCESS, 1'b0, mal);
					owe(KIND_REPLY, BYTE_ZERO, 1'b0, mal);
					owe(KIND_REPLY, RSP_LEN_SHORT, 1'b1, mal);
					ses = SES_DISCONN;
				end
				default: ;
			endcase
			phase = PH_OPCODE;
		endfunction

		// advance the parse by one accepted rx byte
		function void take_client_byte(logic [7:0] b);
			int          first;
			int          i;
			logic [15:0] hlen;
			first = owed_beats.size();
			if (ses == SES_DISCONN)
				return;
			case (phase)
				PH_OPCODE: begin
					op = b;
					seen = 16'd1;
					phase = PH_LEN_HI;
				end
				PH_LEN_HI: begin
					len_hi = b;
					seen = 16'd2;
					phase = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					pkt_len = {len_hi, b};
					seen = FIXED_LEN;
					case (op_class())
						CLS_CONNECT: phase = PH_VER;
						CLS_OTHER: begin
							if (seen >= pkt_len) phase = PH_OPCODE;
							else phase = PH_SKIP;
						end
						default: begin
							if (seen >= pkt_len) close_packet(1'b0);
							else phase = PH_HDR_ID;
						end
					endcase
				end
				PH_VER: begin
					version = b;
					seen = 16'd4;
					phase = PH_FLAGS;
				end
				PH_FLAGS: begin
					seen = 16'd5;
					phase = PH_MAX_HI;
				end
				PH_MAX_HI: begin
					max_size = {b, 8'h00};
					seen = 16'd6;
					phase = PH_MAX_LO;
				end
				PH_MAX_LO: begin
					max_size[7:0] = b;
					seen = CONNECT_LEN;
					if (seen >= pkt_len) close_packet(1'b0);
					else phase = PH_HDR_ID;
				end
				PH_SKIP: begin
					seen = seen + 16'd1;
					if (seen >= pkt_len) phase = PH_OPCODE;
				end
				PH_HDR_ID, PH_HLEN_HI, PH_HLEN_LO, PH_HDATA: begin
					seen = seen + 16'd1;
					case (phase)
						PH_HDR_ID: begin
							hdr_id = b;
							if (b == HDR_BODY || b == HDR_EOB || b[7:6] <= FORM_SEQ_MAX) begin
								phase = PH_HLEN_HI;
							end else begin
								if (b[7:6] == FORM_ONE_BYTE) hdr_left = REM_ONE_BYTE;
								else hdr_left = REM_FOUR_BYTE;
								phase = PH_HDATA;
							end
						end
						PH_HLEN_HI: begin
							len_hi = b;
							phase = PH_HLEN_LO;
						end
						PH_HLEN_LO: begin
							hlen = {len_hi, b};
							hdr_left = (hlen >= HLEN_OVERHEAD) ? hlen - HLEN_OVERHEAD : 16'd0;
							if (hdr_left != 0) phase = PH_HDATA;
							else phase = PH_HDR_ID;
						end
						default: begin
							if (hdr_id == HDR_BODY || hdr_id == HDR_EOB)
								owe(KIND_BODY, b, 1'b1, 1'b0);
							if (hdr_left != 0) hdr_left = hdr_left - 16'd1;
							if (hdr_left == 0) phase = PH_HDR_ID;
						end
					endcase
					if (seen >= pkt_len) close_packet(phase != PH_HDR_ID);
				end
				default: phase = PH_OPCODE;
			endcase
			// every beat of this byte carries the session after it
			for (i = first; i < owed_beats.size(); i++)
				owed_beats[i].ses = ses;
		endfunction

		function void match_tx_beat(tx_beat_t got);
			tx_beat_t want;
			if (owed_beats.size() == 0) begin
				beat_errors++;
				$display("%0t: tx beat with nothing owed: kind %0d byte %h last %0d ses %0d mal %0d",
					$time, got.kind, got.data, got.last, got.ses, got.mal);
				return;
			end
			want = owed_beats.pop_front();
			beats_checked++;
			if (got.kind !== want.kind || got.data !== want.data || got.last !== want.last ||
					got.ses !== want.ses || got.mal !== want.mal) begin
				beat_errors++;
				$display({"%0t: tx beat mismatch: expected kind %0d byte %h last %0d ses %0d mal %0d,",
					" actual kind %0d byte %h last %0d ses %0d mal %0d"}, $time,
					want.kind, want.data, want.last, want.ses, want.mal,
					got.kind, got.data, got.last, got.ses, got.mal);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	opp_rx_if rx();
	opp_tx_if tx();

	obex_server_packet_parser_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.tx     (tx)
	);

	obex_reply_book book;
	logic [7:0]     req_bytes[$];
	logic [7:0]     hdr_bytes[$];
	int             send_idle_pct;
	int             recv_stall_pct;
	bit             hold_req;
	int             bytes_sent;
	int             requests_sent;
	int             quiet_cycles;

	// known request bytes: short connect, put with body and short eob, skipped, overrun
	logic [7:0] opening [27] = '{
		OP_CONNECT, 8'h00, 8'h05, 8'h10, BYTE_ZERO, 8'hFF, 8'hFF,
		OP_PUT & ~FINAL_MASK, 8'h00, 8'h0B, HDR_BODY, 8'h00, 8'h05, 8'h00, 8'hFF,
		HDR_EOB, 8'h00, 8'h02,
		SKIPPED_OP, 8'h00, 8'h04, 8'hAA,
		OP_PUT, 8'h00, 8'h05, FOUR_BYTE_ID, 8'h11
	};

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// one header, well formed unless wild (random length field, cut by the packet)
	function automatic void append_header(input bit wild);
		logic [7:0]  id;
		logic [15:0] hlen;
		int          n;
		int          pick;
		pick = $urandom_range(9);
		case (pick)
			0, 1, 2: id = HDR_BODY;
			3:       id = HDR_EOB;
			4:       id = {FORM_TEXT, 6'($urandom_range(63))};
			5:       id = {FORM_SEQ_MAX, 6'($urandom_range(63))};
			6:       id = {FORM_ONE_BYTE, 6'($urandom_range(63))};
			7:       id = {FORM_FOUR_BYTE, 6'($urandom_range(63))};
			default: id = 8'($urandom);
		endcase
		hdr_bytes.push_back(id);
		if (id == HDR_BODY || id == HDR_EOB || id[7:6] <= FORM_SEQ_MAX) begin
			n = $urandom_range(6);
			if (wild) begin
				hlen = 16'($urandom);
				n = 6;
			end else if (pick == 9) begin
				hlen = 16'($urandom_range(2));
				n = 0;
			end else begin
				hlen = 16'(n) + HLEN_OVERHEAD;
			end
			hdr_bytes.push_back(hlen[15:8]);
			hdr_bytes.push_back(hlen[7:0]);
		end else begin
			n = (id[7:6] == FORM_ONE_BYTE) ? 1 : 4;
		end
		repeat (n) hdr_bytes.push_back(8'($urandom));
	endfunction

	// build one request into req_bytes, sending its declared length but never fewer than its fixed fields
	function automatic void compose_request(input req_kind_t kind, input shape_t shape);
		logic [7:0]  op;
		logic [15:0] max_sz;
		logic [15:0] plen;
		int          fixed;
		int          total;
		int          i;
		req_bytes.delete();
		hdr_bytes.delete();
		if (kind == REQ_SKIP) begin
			do op = 8'($urandom);
			while ((op | FINAL_MASK) == OP_CONNECT || (op | FINAL_MASK) == OP_PUT ||
				(op | FINAL_MASK) == OP_DISC);
			plen = 16'($urandom_range(12));
			req_bytes.push_back(op);
			req_bytes.push_back(plen[15:8]);
			req_bytes.push_back(plen[7:0]);
			for (i = int'(FIXED_LEN); i < int'(plen); i++)
				req_bytes.push_back(8'($urandom));
			return;
		end
		case (kind)
			REQ_CONNECT: op = OP_CONNECT;
			REQ_PUT:     op = OP_PUT;
			default:     op = OP_DISC;
		endcase
		if ($urandom_range(1) == 0) op = op & ~FINAL_MASK;
		fixed = (kind == REQ_CONNECT) ? int'(CONNECT_LEN) : int'(FIXED_LEN);
		if (shape != SHAPE_SHORT)
			repeat ($urandom_range(3)) append_header(1'b0);
		if (shape == SHAPE_CUT) append_header(1'b1);
		total = fixed + hdr_bytes.size();
		case (shape)
			SHAPE_WHOLE: plen = 16'(total);
			SHAPE_SHORT: plen = 16'($urandom_range(fixed));
			default:     plen = 16'($urandom_range(total - 1, fixed + 1));
		endcase
		req_bytes.push_back(op);
		req_bytes.push_back(plen[15:8]);
		req_bytes.push_back(plen[7:0]);
		if (kind == REQ_CONNECT) begin
			max_sz = 16'($urandom);
			if ($urandom_range(3) == 0) max_sz = ($urandom_range(1) == 0) ? 16'h0000 : 16'hFFFF;
			req_bytes.push_back(8'($urandom));
			req_bytes.push_back(8'($urandom));
			req_bytes.push_back(max_sz[15:8]);
			req_bytes.push_back(max_sz[7:0]);
		end
		for (i = 0; i < int'(plen) - fixed; i++)
			req_bytes.push_back(hdr_bytes[i]);
	endfunction

	// offer one rx beat, with random idle cycles ahead of it
	task automatic send_byte(input logic [7:0] b);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			rx.valid <= 1'b0;
			@(posedge clk);
		end
		rx.valid <= 1'b1;
		rx.in_byte <= b;
		do @(posedge clk);
		while (rx.ready !== 1'b1);
		book.take_client_byte(b);
		bytes_sent++;
	endtask

	task automatic send_request(input req_kind_t kind, input shape_t shape);
		compose_request(kind, shape);
		foreach (req_bytes[i]) send_byte(req_bytes[i]);
		requests_sent++;
	endtask

	// random requests until about n more bytes went in
	task automatic run_phase(input int n);
		int        start;
		int        r;
		req_kind_t kind;
		shape_t    shape;
		start = bytes_sent;
		while (bytes_sent - start < n) begin
			r = $urandom_range(99);
			if (r < 15) kind = REQ_CONNECT;
			else if (r < 82) kind = REQ_PUT;
			else kind = REQ_SKIP;
			r = $urandom_range(99);
			if (r < 68) shape = SHAPE_WHOLE;
			else if (r < 80) shape = SHAPE_SHORT;
			else shape = SHAPE_CUT;
			send_request(kind, shape);
		end
	endtask

	task automatic drain_replies();
		while (book.owed_beats.size() != 0) @(posedge clk);
	endtask

	// tx sink: check beats, random stalls and one long hold-off
	initial begin
		int       hold_left;
		bit       hold_done;
		tx_beat_t got;
		hold_left = 0;
		hold_done = 1'b0;
		tx.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (tx.valid === 1'b1 && tx.ready === 1'b1) begin
				got.kind = tx.out_kind;
				got.data = tx.out_byte;
				got.last = tx.run_last;
				got.ses = tx.session;
				got.mal = tx.malformed;
				book.match_tx_beat(got);
			end
			if (hold_req && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				tx.ready <= 1'b0;
				hold_left--;
			end else begin
				tx.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// watchdog on cycles with no beat moving on either side
	initial quiet_cycles = 0;
	always @(posedge clk) begin
		if ((rx.valid === 1'b1 && rx.ready === 1'b1) || (tx.valid === 1'b1 && tx.ready === 1'b1))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_obex_server_packet_parser_unit NOT OK");
			$finish;
		end
	end

	// main sequence
	initial begin
		book = new();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req = 1'b0;
		bytes_sent = 0;
		requests_sent = 0;
		arst_n = 1'b0;
		rx.valid <= 1'b0;
		rx.in_byte <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed opening, no idling
		foreach (opening[i]) send_byte(opening[i]);
		requests_sent += 4;

		// no idling, with the sink held off for a long stretch
		hold_req = 1'b1;
		run_phase(PHASE_BYTES);

		// sparse sender, then a pause until all replies are out
		send_idle_pct = 84;
		run_phase(PHASE_BYTES);
		rx.valid <= 1'b0;
		drain_replies();

		// stalling sink
		send_idle_pct = 0;
		recv_stall_pct = 84;
		run_phase(PHASE_BYTES);

		// light idling on both sides, then disconnect and bytes that get dropped
		send_idle_pct = 17;
		recv_stall_pct = 17;
		run_phase(PHASE_BYTES);
		send_request(REQ_BYE, shape_t'($urandom_range(2)));
		repeat (4) send_byte(8'($urandom));
		rx.valid <= 1'b0;

		drain_replies();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d client bytes in %0d requests: connect, put, skipped, short, cut",
			bytes_sent, requests_sent);
		$display("%0d tx beats checked under four flow mixes, a long sink hold and a drain pause",
			book.beats_checked);
		if (book.beat_errors == 0 && book.owed_beats.size() == 0)
			$display("tb_obex_server_packet_parser_unit OK");
		else
			$display("tb_obex_server_packet_parser_unit NOT OK");
		$finish;
	end

endmodule
